// ===== sv/mjs_pkg.sv =====
package mjs_pkg;

  // Setup commands beyond this count are never issued.
  localparam logic [3:0] MAX_SETUP_CMDS = 4'd8;

  localparam logic [31:0] DEFAULT_INTERVAL = 32'd300000;
  localparam logic [31:0] DEFAULT_DELAY    = 32'd1000;

  localparam logic [3:0] RESET_SETUP_COUNT = 4'd5;
  localparam logic [7:0] RESET_RETRY_LIMIT = 8'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SETUP_COUNT   = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
  localparam logic [1:0] REG_SEND_INTERVAL = 2'd2;
  localparam logic [1:0] REG_RETRY_DELAY   = 2'd3;

  // Send response classes.
  localparam logic [1:0] SRES_UNKNOWN = 2'd0;
  localparam logic [1:0] SRES_OK      = 2'd1;
  localparam logic [1:0] SRES_TIMEOUT = 2'd2;
  localparam logic [1:0] SRES_ERROR   = 2'd3;

  // Command kinds on the result channel.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SETUP = 2'd1;
  localparam logic [1:0] KIND_JOIN  = 2'd2;
  localparam logic [1:0] KIND_SEND  = 2'd3;

  // Phase numbers reported on the result channel.
  localparam logic [3:0] PHASE_INIT              = 4'd0;
  localparam logic [3:0] PHASE_SEND_CMD          = 4'd1;
  localparam logic [3:0] PHASE_WAIT_OK           = 4'd2;
  localparam logic [3:0] PHASE_SEND_JOIN         = 4'd3;
  localparam logic [3:0] PHASE_WAIT_JOIN_OK      = 4'd4;
  localparam logic [3:0] PHASE_SEND_PERIODIC     = 4'd5;
  localparam logic [3:0] PHASE_WAIT_SEND_RESP    = 4'd6;
  localparam logic [3:0] PHASE_WAIT_SEND_INTERVAL = 4'd7;
  localparam logic [3:0] PHASE_JOIN_RETRY        = 4'd8;
  localparam logic [3:0] PHASE_DONE              = 4'd9;
  localparam logic [3:0] PHASE_ERROR             = 4'd10;

  typedef enum logic [10:0] {
    ST_INIT              = 11'b000_0000_0001,
    ST_SEND_CMD          = 11'b000_0000_0010,
    ST_WAIT_OK           = 11'b000_0000_0100,
    ST_SEND_JOIN         = 11'b000_0000_1000,
    ST_WAIT_JOIN_OK      = 11'b000_0001_0000,
    ST_SEND_PERIODIC     = 11'b000_0010_0000,
    ST_WAIT_SEND_RESP    = 11'b000_0100_0000,
    ST_WAIT_SEND_INTERVAL = 11'b000_1000_0000,
    ST_JOIN_RETRY        = 11'b001_0000_0000,
    ST_DONE              = 11'b010_0000_0000,
    ST_ERROR             = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic [3:0]  setup_count;
    logic [7:0]  retry_limit;
    logic [31:0] send_interval;
    logic [31:0] retry_delay;
  } mjs_cfg_t;

  typedef struct packed {
    logic        rx_present;
    logic        generic_ok;
    logic        join_ok;
    logic [1:0]  send_result;
    logic [31:0] now_ms;
  } mjs_tick_t;

  typedef struct packed {
    logic [1:0]  command_kind;
    logic [3:0]  command_number;
    logic [3:0]  phase;
    logic [15:0] sends_done;
    logic [7:0]  errors_seen;
  } mjs_result_t;

  function automatic logic [3:0] phase_code(input state_t st);
    logic [3:0] code;
    case (st)
      ST_INIT:               code = PHASE_INIT;
      ST_SEND_CMD:           code = PHASE_SEND_CMD;
      ST_WAIT_OK:            code = PHASE_WAIT_OK;
      ST_SEND_JOIN:          code = PHASE_SEND_JOIN;
      ST_WAIT_JOIN_OK:       code = PHASE_WAIT_JOIN_OK;
      ST_SEND_PERIODIC:      code = PHASE_SEND_PERIODIC;
      ST_WAIT_SEND_RESP:     code = PHASE_WAIT_SEND_RESP;
      ST_WAIT_SEND_INTERVAL: code = PHASE_WAIT_SEND_INTERVAL;
      ST_JOIN_RETRY:         code = PHASE_JOIN_RETRY;
      ST_DONE:               code = PHASE_DONE;
      ST_ERROR:              code = PHASE_ERROR;
      default:               code = PHASE_INIT;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/mjs_cfg.sv =====
module mjs_cfg
  import mjs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  input  logic        delay_reload,
  output mjs_cfg_t    cfg
);

  logic [3:0]  setup_count_r;
  logic [7:0]  retry_limit_r;
  logic [31:0] send_interval_r;
  logic [31:0] retry_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_count_r   <= RESET_SETUP_COUNT;
      retry_limit_r   <= RESET_RETRY_LIMIT;
      send_interval_r <= DEFAULT_INTERVAL;
      retry_delay_r   <= DEFAULT_DELAY;
    end else if (wr_en) begin
      case (wr_index)
        REG_SETUP_COUNT:   setup_count_r   <= wr_data[3:0];
        REG_RETRY_LIMIT:   retry_limit_r   <= wr_data[7:0];
        REG_SEND_INTERVAL: send_interval_r <= wr_data;
        REG_RETRY_DELAY:   retry_delay_r   <= wr_data;
        default: ;
      endcase
    end else if (delay_reload) begin
      // The sequencer restores the retry delay on init, join success and a send answered OK or timeout.
      retry_delay_r <= DEFAULT_DELAY;
    end
  end

  assign cfg.setup_count   = setup_count_r;
  assign cfg.retry_limit   = retry_limit_r;
  assign cfg.send_interval = send_interval_r;
  assign cfg.retry_delay   = retry_delay_r;

endmodule

// ===== sv/mjs_core.sv =====
module mjs_core
  import mjs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  mjs_tick_t   tick,
  input  mjs_cfg_t    cfg,
  output logic        delay_reload,
  output mjs_result_t result
);

  state_t      state_r, state_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] sends_r, sends_nxt;
  logic [7:0]  err_r, err_nxt;
  logic [31:0] send_stamp_r, send_stamp_nxt;
  logic [31:0] retry_stamp_r, retry_stamp_nxt;

  logic [3:0]  setup_limit;
  logic [7:0]  err_inc;
  logic [31:0] interval;
  logic [31:0] send_elapsed;
  logic [31:0] retry_elapsed;
  logic [1:0]  kind;
  logic [3:0]  number;
  logic        reload;

  assign setup_limit   = (cfg.setup_count > MAX_SETUP_CMDS) ? MAX_SETUP_CMDS : cfg.setup_count;
  assign err_inc       = (err_r != 8'hFF) ? err_r + 8'd1 : err_r;
  assign interval      = (cfg.send_interval != 32'd0) ? cfg.send_interval : DEFAULT_INTERVAL;
  assign send_elapsed  = tick.now_ms - send_stamp_r;
  assign retry_elapsed = tick.now_ms - retry_stamp_r;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    sends_nxt       = sends_r;
    err_nxt         = err_r;
    send_stamp_nxt  = send_stamp_r;
    retry_stamp_nxt = retry_stamp_r;
    kind            = KIND_NONE;
    number          = 4'd0;
    reload          = 1'b0;
    case (state_r)
      ST_INIT: begin
        idx_nxt         = 4'd0;
        err_nxt         = 8'd0;
        retry_stamp_nxt = 32'd0;
        reload          = 1'b1;
        state_nxt       = ST_SEND_CMD;
      end
      ST_SEND_CMD: begin
        if (idx_r < setup_limit) begin
          kind      = KIND_SETUP;
          number    = idx_r;
          state_nxt = ST_WAIT_OK;
        end else begin
          state_nxt = ST_SEND_JOIN;
        end
      end
      ST_WAIT_OK: begin
        if (tick.rx_present && tick.generic_ok) begin
          if (idx_r < setup_limit) begin
            idx_nxt = idx_r + 4'd1;
          end
          state_nxt = ST_SEND_CMD;
        end
      end
      ST_SEND_JOIN: begin
        kind      = KIND_JOIN;
        state_nxt = ST_WAIT_JOIN_OK;
      end
      ST_WAIT_JOIN_OK: begin
        if (tick.rx_present && tick.join_ok) begin
          state_nxt       = ST_SEND_PERIODIC;
          sends_nxt       = 16'd0;
          err_nxt         = 8'd0;
          retry_stamp_nxt = 32'd0;
          reload          = 1'b1;
        end
      end
      ST_SEND_PERIODIC: begin
        kind = KIND_SEND;
        if (sends_r != 16'hFFFF) begin
          sends_nxt = sends_r + 16'd1;
        end
        state_nxt = ST_WAIT_SEND_RESP;
      end
      ST_WAIT_SEND_RESP: begin
        if (tick.rx_present) begin
          if (tick.send_result == SRES_OK || tick.send_result == SRES_TIMEOUT) begin
            state_nxt      = ST_WAIT_SEND_INTERVAL;
            err_nxt        = 8'd0;
            reload         = 1'b1;
            send_stamp_nxt = tick.now_ms;
          end else if (tick.send_result == SRES_ERROR) begin
            err_nxt = err_inc;
            // A zero limit means the join is retried without end.
            if (cfg.retry_limit == 8'd0 || err_inc < cfg.retry_limit) begin
              state_nxt = ST_JOIN_RETRY;
            end else begin
              state_nxt = ST_ERROR;
            end
          end
        end
      end
      ST_WAIT_SEND_INTERVAL: begin
        if (send_elapsed >= interval) begin
          state_nxt = ST_SEND_PERIODIC;
        end
      end
      ST_JOIN_RETRY: begin
        // A zero stamp marks that no retry has been taken, so it goes at once.
        if (retry_stamp_r == 32'd0 || retry_elapsed >= cfg.retry_delay) begin
          retry_stamp_nxt = tick.now_ms;
          state_nxt       = ST_SEND_JOIN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      idx_r         <= 4'd0;
      sends_r       <= 16'd0;
      err_r         <= 8'd0;
      send_stamp_r  <= 32'd0;
      retry_stamp_r <= 32'd0;
    end else if (step_en) begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      sends_r       <= sends_nxt;
      err_r         <= err_nxt;
      send_stamp_r  <= send_stamp_nxt;
      retry_stamp_r <= retry_stamp_nxt;
    end
  end

  assign delay_reload          = step_en && reload;
  assign result.command_kind   = kind;
  assign result.command_number = number;
  assign result.phase          = phase_code(state_nxt);
  assign result.sends_done     = sends_nxt;
  assign result.errors_seen    = err_nxt;

endmodule

// ===== sv/modem_join_and_send_sequencer.sv =====
// Modem join-and-send sequencer.
// Each request on the in_ channel is one process tick: classified modem
// response flags plus the current millisecond time. Every tick yields exactly
// one request on the out_ channel with the command issued (none, setup, join
// or data send), the setup command number, the phase after the tick and the
// saturating send and error counts.
// A tick accepted into the s1 register moves on to the result register once
// that register is free, which raises out_valid. One tick is taken every
// cycle while in_stall is low; the only loop is the state register update.
// The cfg_ channel writes the four registers (setup count, retry limit, send
// interval, retry delay); cfg_ready is always high. Write only while no tick
// is in flight.
// Synchronous reset (rst_n low) empties both stages, puts the sequencer in
// its init phase and restores the register defaults. When out_stall is high
// the result holds and one further tick is buffered; then in_stall rises.
module modem_join_and_send_sequencer
  import mjs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_rx_present,
  input  logic        in_generic_ok,
  input  logic        in_join_ok,
  input  logic [1:0]  in_send_result,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command_kind,
  output logic [3:0]  out_command_number,
  output logic [3:0]  out_phase,
  output logic [15:0] out_sends_done,
  output logic [7:0]  out_errors_seen,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic        s1_valid_r, s1_valid_nxt;
  mjs_tick_t   s1_tick_r;
  logic        out_valid_r, out_valid_nxt;
  mjs_result_t out_res_r;
  mjs_result_t step_res;
  mjs_cfg_t    cfg;
  logic        s2_free;
  logic        s1_move;
  logic        in_take;
  logic        delay_reload;

  assign s2_free  = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_tick_r.rx_present  <= in_rx_present;
      s1_tick_r.generic_ok  <= in_generic_ok;
      s1_tick_r.join_ok     <= in_join_ok;
      s1_tick_r.send_result <= in_send_result;
      s1_tick_r.now_ms      <= in_now_ms;
    end
    if (s1_move) begin
      out_res_r <= step_res;
    end
  end

  assign cfg_ready = 1'b1;

  mjs_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (cfg_valid && cfg_ready),
    .wr_index     (cfg_index),
    .wr_data      (cfg_wdata),
    .delay_reload (delay_reload),
    .cfg          (cfg)
  );

  mjs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_move),
    .tick         (s1_tick_r),
    .cfg          (cfg),
    .delay_reload (delay_reload),
    .result       (step_res)
  );

  assign out_valid          = out_valid_r;
  assign out_command_kind   = out_res_r.command_kind;
  assign out_command_number = out_res_r.command_number;
  assign out_phase          = out_res_r.phase;
  assign out_sends_done     = out_res_r.sends_done;
  assign out_errors_seen    = out_res_r.errors_seen;

`ifndef ASSERT_OFF
  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("stepped tick did not reach the result register");

  a_held_tick_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_free) |=> (s1_valid_r && $stable(s1_tick_r)))
    else $error("buffered tick lost while the result was stalled");

  a_setup_waits_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.command_kind == KIND_SETUP) |->
      (out_res_r.phase == PHASE_WAIT_OK))
    else $error("setup command not followed by the wait for OK");

  a_join_waits_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.command_kind == KIND_JOIN) |->
      (out_res_r.phase == PHASE_WAIT_JOIN_OK))
    else $error("join command not followed by the wait for acknowledgement");
`endif

endmodule
